// ----- rtl/fbr_pkg.sv -----
// shared types, constants and helpers of the page frame buffer refresh engine
package fbr_pkg;

    localparam int SCREEN_WIDTH = 128;
    localparam int SCREEN_PAGES = 8;
    localparam int SCREEN_ROWS  = SCREEN_PAGES * 8;
    localparam int STORE_BYTES  = SCREEN_WIDTH * SCREEN_PAGES;
    localparam int PAGE_SPAN    = SCREEN_WIDTH + 3;
    localparam int PREAMBLE_LEN = 3;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int SLOT_W = $clog2(PAGE_SPAN);
    localparam int PAGE_W = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CMD_COL_LOW  = 8'h02;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] PAGE_MASK    = 8'h0F;

    localparam logic [1:0] MODE_PIXEL   = 2'd0;
    localparam logic [1:0] MODE_CLEAR   = 2'd1;
    localparam logic [1:0] MODE_REFRESH = 2'd2;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_CLEAR,
        OP_REFRESH
    } fbr_op_t;

    // one queued command from the front end to the back end
    typedef struct packed {
        fbr_op_t           op;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic              bit_val;
        logic              is_data;
        logic [7:0]        cmd_byte;
        logic              last;
    } fbr_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fbr_qstat_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PIXEL,
        ST_CLEAR,
        ST_FETCH
    } fbr_state_t;

    // command byte for slot 0..2 of a page header
    function automatic logic [7:0] command_byte(input logic [SLOT_W-1:0] slot,
                                                input logic [PAGE_W-1:0] page);
        logic [7:0] res;
        begin
            if (slot == SLOT_W'(0))
            begin
                res = CMD_COL_LOW;
            end
            else if (slot == SLOT_W'(1))
            begin
                res = CMD_COL_HIGH;
            end
            else
            begin
                res = CMD_PAGE | (8'(page) & PAGE_MASK);
            end
            return res;
        end
    endfunction

endpackage

// ----- rtl/fbr_front.sv -----
// front end: accepts transactions, classifies them and tracks the refresh stream position
module fbr_front
    import fbr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     mode,
    input  logic [7:0]     pixel_x,
    input  logic [7:0]     pixel_y,
    input  logic           pixel_on,
    input  logic           invert,
    input  logic           init_busy,
    input  fbr_qstat_t     q_stat,
    output logic           push,
    output fbr_cmd_t       push_cmd
);

    logic              preamble_reg, preamble_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [PAGE_W-1:0] page_reg, page_next;

    logic              accept;
    logic              pix_in_range;
    logic              slot_is_cmd;
    logic              last_byte;
    logic [ADDR_W-1:0] pix_addr;
    logic [ADDR_W-1:0] data_addr;

    assign in_ready = !init_busy && !q_stat.full;
    assign accept   = in_valid && in_ready;

    assign pix_in_range = (32'(pixel_x) < SCREEN_WIDTH) && (32'(pixel_y) < SCREEN_ROWS);
    assign pix_addr     = ADDR_W'(pixel_y >> 3) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(pixel_x);

    // data bytes start after the three header commands of a page
    assign slot_is_cmd = preamble_reg || (slot_reg < SLOT_W'(3));
    assign data_addr   = ADDR_W'(page_reg) * ADDR_W'(SCREEN_WIDTH)
                       + ADDR_W'(slot_reg - SLOT_W'(3));
    assign last_byte   = !preamble_reg && (page_reg == PAGE_W'(SCREEN_PAGES - 1))
                       && (slot_reg == SLOT_W'(PAGE_SPAN - 1));

    always_comb
    begin
        push_cmd          = '0;
        push_cmd.op       = OP_PIXEL;
        push_cmd.addr     = pix_addr;
        push_cmd.bit_sel  = pixel_y[2:0];
        push_cmd.bit_val  = pixel_on ^ invert;
        push              = 1'b0;
        case (mode)
            MODE_PIXEL:
            begin
                push = accept && pix_in_range;
            end
            MODE_CLEAR:
            begin
                push_cmd.op = OP_CLEAR;
                push        = accept;
            end
            MODE_REFRESH:
            begin
                push_cmd.op       = OP_REFRESH;
                push_cmd.addr     = data_addr;
                push_cmd.is_data  = !slot_is_cmd;
                push_cmd.cmd_byte = command_byte(slot_reg, page_reg);
                push_cmd.last     = last_byte;
                push              = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        preamble_next = preamble_reg;
        slot_next     = slot_reg;
        page_next     = page_reg;
        if (accept && (mode == MODE_REFRESH))
        begin
            if (preamble_reg)
            begin
                if (slot_reg == SLOT_W'(PREAMBLE_LEN - 1))
                begin
                    preamble_next = 1'b0;
                    slot_next     = '0;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            else if (slot_reg == SLOT_W'(PAGE_SPAN - 1))
            begin
                slot_next = '0;
                if (page_reg == PAGE_W'(SCREEN_PAGES - 1))
                begin
                    page_next     = '0;
                    preamble_next = 1'b1;
                end
                else
                begin
                    page_next = page_reg + PAGE_W'(1);
                end
            end
            else
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg <= 1'b1;
            slot_reg     <= '0;
            page_reg     <= '0;
        end
        else
        begin
            preamble_reg <= preamble_next;
            slot_reg     <= slot_next;
            page_reg     <= page_next;
        end
    end

endmodule

// ----- rtl/fbr_queue.sv -----
// short command queue between front end and back end
module fbr_queue
    import fbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  fbr_cmd_t   push_cmd,
    input  logic       pop,
    output fbr_cmd_t   head,
    output fbr_qstat_t q_stat
);

    fbr_cmd_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == QCNT_W'(0));
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/fbr_back.sv -----
// back end: frame store memory, pixel read-modify-write, clear sweep and refresh output
module fbr_back
    import fbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fbr_cmd_t   head,
    input  fbr_qstat_t q_stat,
    output logic       pop,
    output logic       init_busy,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_data,
    output logic [7:0] out_byte,
    output logic       frame_end
);

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        rdata_reg;

    fbr_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    fbr_cmd_t          cur_reg;

    logic              out_valid_reg, out_valid_next;
    logic              is_data_reg;
    logic [7:0]        out_byte_reg;
    logic              frame_end_reg;

    logic              out_free;
    logic              clr_done;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        bit_mask;
    logic              load_cmd;
    logic              load_data;

    assign out_free  = !out_valid_reg || out_ready;
    assign clr_done  = (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1));
    assign bit_mask  = 8'(1) << cur_reg.bit_sel;
    assign init_busy = (state_reg == ST_INIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (head.op)
                        OP_PIXEL:   state_next = ST_PIXEL;
                        OP_CLEAR:   state_next = ST_CLEAR;
                        OP_REFRESH:
                        begin
                            if (out_free && head.is_data)
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIXEL, ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = clr_cnt_reg;
        wr_data   = 8'h00;
        load_cmd  = 1'b0;
        load_data = 1'b0;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (head.op)
                        OP_PIXEL:
                        begin
                            pop   = 1'b1;
                            rd_en = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            pop = 1'b1;
                        end
                        OP_REFRESH:
                        begin
                            if (out_free)
                            begin
                                pop      = 1'b1;
                                rd_en    = head.is_data;
                                load_cmd = !head.is_data;
                            end
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_PIXEL:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg.addr;
                wr_data = cur_reg.bit_val ? (rdata_reg | bit_mask) : (rdata_reg & ~bit_mask);
            end
            ST_FETCH:
            begin
                load_data = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if ((state_reg == ST_INIT) || (state_reg == ST_CLEAR))
        begin
            clr_cnt_next = clr_done ? '0 : clr_cnt_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_cmd || load_data)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[head.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (load_cmd)
        begin
            is_data_reg   <= 1'b0;
            out_byte_reg  <= head.cmd_byte;
            frame_end_reg <= head.last;
        end
        else if (load_data)
        begin
            is_data_reg   <= 1'b1;
            out_byte_reg  <= rdata_reg;
            frame_end_reg <= cur_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_data   = is_data_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

endmodule

// ----- rtl/page_framebuffer_refresh_engine.sv -----
// top level of the page frame buffer refresh engine
//
// 128x64 monochrome frame store kept as 8 pages of 128 bytes (pixel x,y is bit y%8
// of byte x + (y/8)*128) plus a refresh stream generator. mode 0 sets or clears one
// pixel (value pixel_on ^ invert, off-screen coordinates ignored), mode 1 zeroes the
// store, mode 2 returns the next stream byte: a preamble 0x02 0x10 0xB0, then for each
// page 0x02 0x10 0xB0|page as commands followed by 128 data bytes, frame_end on the
// last one. mode 3 does nothing. only refresh transactions produce an output
// transaction. after reset the store is swept to zero, during which in_ready stays
// low. the front end takes one transaction per cycle while its 2-entry command queue
// has room; the back end, bound by the single-port frame store, does a pixel write as
// a read then a write, loads a command byte straight from the queue, fetches a data
// byte by a memory read and does a clear as a sweep of one byte per cycle. a result
// sits in an output register, so the back end keeps working while it waits for
// out_ready as long as the next command is not a refresh.
module page_framebuffer_refresh_engine
    import fbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] pixel_x,
    input  logic [7:0] pixel_y,
    input  logic       pixel_on,
    input  logic       invert,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_data,
    output logic [7:0] out_byte,
    output logic       frame_end
);

    // front to queue
    logic       push;
    fbr_cmd_t   push_cmd;

    // queue to back
    logic       pop;
    fbr_cmd_t   head;
    fbr_qstat_t q_stat;

    // back reports the reset clearing sweep
    logic       init_busy;

    fbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pixel_on  (pixel_on),
        .invert    (invert),
        .init_busy (init_busy),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    fbr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    fbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .init_busy (init_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_data   (is_data),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

`ifndef SYNTH
    // nothing enters while the store is still being cleared after reset
    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !(in_valid && in_ready))
        else $error("transaction accepted during reset clearing sweep");

    // the command queue never takes an entry while full
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("command queue overflow");

    // the back end never pops an empty queue
    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("command queue underflow");

    // end of frame is always marked on a data byte
    a_frame_end_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> is_data)
        else $error("frame end flagged on a command byte");
`endif

endmodule

// ----- verif/page_framebuffer_refresh_engine_test.sv -----
// self-checking testbench of the page frame buffer refresh engine
module page_framebuffer_refresh_engine_test;
    import fbr_pkg::*;

    // the package has no name for the unused mode code
    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam int STREAM_LEN     = PREAMBLE_LEN + SCREEN_PAGES * PAGE_SPAN;
    localparam int RANDOM_ITEMS   = 1680;
    localparam int TAIL_ITEMS     = 300;   // last stretch runs without any idling
    localparam int DRAIN_CYCLES   = 1100;  // a clear may still be sweeping at the end
    localparam int WATCHDOG_LIMIT = 6000;  // reset sweep or clear, plus stalls, several times

    // one input transaction
    typedef struct {
        logic [1:0] mode;
        logic [7:0] x;
        logic [7:0] y;
        logic       on;
        logic       inv;
    } fb_item_t;

    // one byte of the refresh stream
    typedef struct {
        logic       is_data;
        logic [7:0] out_byte;
        logic       frame_end;
    } stream_byte_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] mode      = MODE_PIXEL;
    logic [7:0] pixel_x   = 8'd0;
    logic [7:0] pixel_y   = 8'd0;
    logic       pixel_on  = 1'b0;
    logic       invert    = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       is_data;
    logic [7:0] out_byte;
    logic       frame_end;

    // shadow copy of the frame store and of the stream position
    logic [7:0]   shadow_store [STORE_BYTES];
    int           stream_pos = 0;

    fb_item_t     pending_items [$];
    stream_byte_t expected_stream [$];
    fb_item_t     cur_item;

    int   item_total     = 0;
    int   accepted_count = 0;
    int   error_count    = 0;
    int   idle_left      = 0;
    int   stall_left     = 0;
    int   quiet_cycles   = 0;
    logic next_valid;
    logic next_ready;
    logic calm;

    page_framebuffer_refresh_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pixel_on  (pixel_on),
        .invert    (invert),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_data   (is_data),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

    always #1 clk = ~clk;

    // header command for slot 0..2 of a page block: low column, high column, page address
    function automatic logic [7:0] header_byte(input int slot, input int page);
        logic [7:0] b;
        begin
            if (slot == 0)
            begin
                b = CMD_COL_LOW;
            end
            else if (slot == 1)
            begin
                b = CMD_COL_HIGH;
            end
            else
            begin
                b = CMD_PAGE | (8'(page) & PAGE_MASK);
            end
            return b;
        end
    endfunction

    // update the shadow state with an accepted transaction and queue the byte it yields
    task automatic absorb_item(input fb_item_t it);
        int           idx;
        int           pos;
        int           q;
        int           page;
        int           slot;
        stream_byte_t r;
        begin
            case (it.mode)
                MODE_PIXEL:
                begin
                    // off-screen coordinates leave the store alone
                    if (it.x < SCREEN_WIDTH && it.y < SCREEN_ROWS)
                    begin
                        idx = int'(it.x) + int'(it.y >> 3) * SCREEN_WIDTH;
                        shadow_store[idx][it.y[2:0]] = it.on ^ it.inv;
                    end
                end
                MODE_CLEAR:
                begin
                    // the stream position survives a clear
                    for (int i = 0; i < STORE_BYTES; i++)
                    begin
                        shadow_store[i] = 8'h00;
                    end
                end
                MODE_REFRESH:
                begin
                    pos = stream_pos;
                    if (pos >= STREAM_LEN)
                    begin
                        pos = 0;
                    end
                    r.is_data = 1'b0;
                    if (pos < PREAMBLE_LEN)
                    begin
                        r.out_byte = header_byte(pos, 0);
                    end
                    else
                    begin
                        q    = pos - PREAMBLE_LEN;
                        page = q / PAGE_SPAN;
                        slot = q % PAGE_SPAN;
                        if (slot < 3)
                        begin
                            r.out_byte = header_byte(slot, page);
                        end
                        else
                        begin
                            r.is_data  = 1'b1;
                            r.out_byte = shadow_store[page * SCREEN_WIDTH + slot - 3];
                        end
                    end
                    // wrap after the last data byte, next frame starts with the preamble
                    r.frame_end = (pos + 1 >= STREAM_LEN);
                    stream_pos  = r.frame_end ? 0 : pos + 1;
                    expected_stream.push_back(r);
                end
                default:
                begin
                    // unused mode: nothing happens
                end
            endcase
        end
    endtask

    task automatic queue_item(input logic [1:0] m, input logic [7:0] x, input logic [7:0] y,
                              input logic on, input logic inv);
        fb_item_t it;
        begin
            it.mode = m;
            it.x    = x;
            it.y    = y;
            it.on   = on;
            it.inv  = inv;
            pending_items.push_back(it);
        end
    endtask

    // input driver: presents queued transactions, holds valid until accepted, idles in bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            calm       = (pending_items.size() < TAIL_ITEMS);
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                absorb_item(cur_item);
                accepted_count++;
                next_valid = 1'b0;
            end
            // only pick up a new transaction while nothing is on offer
            if (!next_valid)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (pending_items.size() > 0)
                begin
                    if (!calm && $urandom_range(0, 5) == 0)
                    begin
                        // this cycle counts as the first idle one of the burst
                        idle_left = $urandom_range(0, 17);
                    end
                    else
                    begin
                        cur_item   = pending_items.pop_front();
                        next_valid = 1'b1;
                    end
                end
            end
            in_valid <= next_valid;
            mode     <= cur_item.mode;
            pixel_x  <= cur_item.x;
            pixel_y  <= cur_item.y;
            pixel_on <= cur_item.on;
            invert   <= cur_item.inv;
        end
    end

    // output monitor: checks each output transaction against the oldest predicted byte
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_stream.size() == 0)
                begin
                    $display("%0t: unexpected output transaction, expected none, got %0b/%02h/%0b",
                             $time, is_data, out_byte, frame_end);
                    error_count++;
                end
                else
                begin
                    if (is_data !== expected_stream[0].is_data)
                    begin
                        $display("%0t: is_data mismatch, expected %0b, got %0b",
                                 $time, expected_stream[0].is_data, is_data);
                        error_count++;
                    end
                    if (out_byte !== expected_stream[0].out_byte)
                    begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, expected_stream[0].out_byte, out_byte);
                        error_count++;
                    end
                    if (frame_end !== expected_stream[0].frame_end)
                    begin
                        $display("%0t: frame_end mismatch, expected %0b, got %0b",
                                 $time, expected_stream[0].frame_end, frame_end);
                        error_count++;
                    end
                    void'(expected_stream.pop_front());
                end
            end
            // receiver stalls in bursts too, except in the tail
            if (pending_items.size() < TAIL_ITEMS)
            begin
                next_ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            out_ready <= next_ready;
        end
    end

    // watchdog: cycles with work outstanding but no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (accepted_count == item_total && expected_stream.size() == 0))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("** page_framebuffer_refresh_engine: FAILED **");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int         r;
        logic [1:0] m;
        logic [7:0] x;
        logic [7:0] y;
        logic       on;
        logic       inv;

        // the store comes out of reset all zero
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            shadow_store[i] = 8'h00;
        end

        // directed: preamble, corner pixels, off-screen pixels, invert, nop, clear
        queue_item(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0);
        queue_item(MODE_REFRESH, 8'd255, 8'd255, 1'b1, 1'b1);
        queue_item(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0);
        queue_item(MODE_PIXEL, 8'd0, 8'd0, 1'b1, 1'b0);
        queue_item(MODE_PIXEL, 8'd127, 8'd63, 1'b1, 1'b0);
        queue_item(MODE_PIXEL, 8'd128, 8'd0, 1'b1, 1'b0);
        queue_item(MODE_PIXEL, 8'd0, 8'd64, 1'b1, 1'b0);
        queue_item(MODE_PIXEL, 8'd255, 8'd255, 1'b1, 1'b1);
        queue_item(MODE_PIXEL, 8'd7, 8'd7, 1'b0, 1'b1);
        queue_item(MODE_PIXEL, 8'd1, 8'd15, 1'b1, 1'b1);
        queue_item(MODE_PIXEL, 8'd1, 8'd0, 1'b0, 1'b0);
        queue_item(MODE_NOP, 8'd200, 8'd100, 1'b1, 1'b1);
        // page 0 header and its first data bytes
        for (int i = 0; i < 5; i++)
        begin
            queue_item(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0);
        end
        queue_item(MODE_CLEAR, 8'd0, 8'd0, 1'b0, 1'b0);
        queue_item(MODE_PIXEL, 8'd2, 8'd0, 1'b1, 1'b0);
        queue_item(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0);
        queue_item(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0);

        // random: mostly refresh and on-screen pixels, enough refreshes to wrap a frame
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r   = $urandom_range(0, 99);
            x   = 8'($urandom_range(0, 255));
            y   = 8'($urandom_range(0, 255));
            on  = 1'($urandom_range(0, 1));
            inv = 1'($urandom_range(0, 1));
            if (r < 72)
            begin
                m = MODE_REFRESH;
            end
            else if (r < 96)
            begin
                m = MODE_PIXEL;
                if ($urandom_range(0, 4) != 0)
                begin
                    x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
                    y = 8'($urandom_range(0, SCREEN_ROWS - 1));
                end
            end
            else if (r < 98)
            begin
                m = MODE_CLEAR;
            end
            else
            begin
                m = MODE_NOP;
            end
            queue_item(m, x, y, on, inv);
        end
        item_total = pending_items.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_count == item_total);
        while (expected_stream.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("** page_framebuffer_refresh_engine: PASSED **");
        end
        else
        begin
            $display("** page_framebuffer_refresh_engine: FAILED **");
        end
        $finish;
    end

endmodule
